FILE: design/infix_to_postfix_converter_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the infix to postfix converter
// Concurrent checks on the converter clock with reset disable.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_TOP_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_TOP_MACROS_SVH

// same-cycle implication
`define ITP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ITP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, token codes and sizes of the infix to postfix converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

  localparam int KIND_W      = 4;
  localparam int OUT_W       = 3;
  localparam int NUM_W       = 64;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  localparam int TQ_DEPTH    = 2;
  localparam int TQ_PTR_W    = $clog2(TQ_DEPTH);
  localparam int TQ_CNT_W    = $clog2(TQ_DEPTH + 1);

  localparam int RQ_DEPTH    = 4;
  localparam int RQ_PTR_W    = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W    = $clog2(RQ_DEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_NUMBER   = 4'd0;
  localparam logic [KIND_W-1:0] KIND_PLUS     = 4'd1;
  localparam logic [KIND_W-1:0] KIND_MINUS    = 4'd2;
  localparam logic [KIND_W-1:0] KIND_TIMES    = 4'd3;
  localparam logic [KIND_W-1:0] KIND_DIVIDE   = 4'd4;
  localparam logic [KIND_W-1:0] KIND_POWER    = 4'd5;
  localparam logic [KIND_W-1:0] KIND_OPEN     = 4'd6;
  localparam logic [KIND_W-1:0] KIND_SIN_OPEN = 4'd7;
  localparam logic [KIND_W-1:0] KIND_COS_OPEN = 4'd8;
  localparam logic [KIND_W-1:0] KIND_CLOSE    = 4'd9;

  localparam logic [OUT_W-1:0] OUT_NUMBER = 3'd0;
  localparam logic [OUT_W-1:0] OUT_SIN    = 3'd6;
  localparam logic [OUT_W-1:0] OUT_COS    = 3'd7;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_NUM,
    CLS_OP,
    CLS_OPEN,
    CLS_CLOSE
  } cls_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    cls_t              cls;
    logic [NUM_W-1:0]  number;
    logic              expr_end;
  } token_t;

  typedef struct packed {
    logic [OUT_W-1:0] kind;
    logic [NUM_W-1:0] number;
    logic             run_last;
    logic             expr_done;
    logic             err;
  } result_t;

  function automatic logic [2:0] prec_of(input logic [KIND_W-1:0] code);
    logic [2:0] p;
    case (code) inside
      KIND_PLUS, KIND_MINUS:  p = 3'd2;
      KIND_TIMES, KIND_DIVIDE: p = 3'd3;
      KIND_POWER:             p = 3'd4;
      default:                p = 3'd1;
    endcase
    return p;
  endfunction

  function automatic logic is_opener(input logic [KIND_W-1:0] code);
    return (code == KIND_OPEN) || (code == KIND_SIN_OPEN) || (code == KIND_COS_OPEN);
  endfunction

endpackage

`default_nettype wire

FILE: design/itp_front.sv
// ----------------------------------------------------------------------------
// itp_front
// Input token queue: accepts items, classifies the token kind, holds them
// until the stack engine takes them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itp_front
  import itp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [KIND_W-1:0] token_kind,
  input  logic [NUM_W-1:0]  number_bits,
  input  logic              expression_end,
  output logic              tok_valid,
  output token_t            tok_head,
  input  logic              tok_take
);

  token_t                q [TQ_DEPTH];
  logic [TQ_PTR_W-1:0]   wr_ptr;
  logic [TQ_PTR_W-1:0]   rd_ptr;
  logic [TQ_CNT_W-1:0]   cnt;
  cls_t                  cls;
  logic                  wr_en;
  logic                  rd_en;

  always_comb begin
    unique case (token_kind) inside
      KIND_NUMBER:                                           cls = CLS_NUM;
      KIND_PLUS, KIND_MINUS, KIND_TIMES, KIND_DIVIDE, KIND_POWER: cls = CLS_OP;
      KIND_OPEN, KIND_SIN_OPEN, KIND_COS_OPEN:               cls = CLS_OPEN;
      KIND_CLOSE:                                            cls = CLS_CLOSE;
      default:                                               cls = CLS_NONE;
    endcase
  end

  assign full      = (cnt == TQ_CNT_W'(TQ_DEPTH));
  assign tok_valid = (cnt != '0);
  assign tok_head  = q[rd_ptr];
  assign wr_en     = push && !full;
  assign rd_en     = tok_take && tok_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == TQ_PTR_W'(TQ_DEPTH - 1)) ? '0 : wr_ptr + TQ_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == TQ_PTR_W'(TQ_DEPTH - 1)) ? '0 : rd_ptr + TQ_PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        cnt <= cnt + TQ_CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        cnt <= cnt - TQ_CNT_W'(1);
      end
    end
    if (wr_en) begin
      q[wr_ptr] <= '{kind: token_kind, cls: cls, number: number_bits,
                     expr_end: expression_end};
    end
  end

endmodule

`default_nettype wire

FILE: design/itp_stack.sv
// ----------------------------------------------------------------------------
// itp_stack
// Operator stack engine: pops one stack entry per cycle (an emitted entry only while the result side has room),
// pushes operators and openers, and builds result items with their run and error flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "infix_to_postfix_converter_top_macros.svh"

module itp_stack
  import itp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    tok_valid,
  input  token_t  tok_head,
  output logic    tok_take,
  output logic    res_wr,
  output result_t res_data,
  input  logic    res_full
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_NUM,
    S_OP,
    S_OPEN,
    S_CLOSE,
    S_FLUSH
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  stack_cnt, stack_cnt_next;
  logic [CNT_W-1:0]  open_cnt, open_cnt_next;
  logic [KIND_W-1:0] top, top_next;
  logic [KIND_W-1:0] below;
  logic [KIND_W-1:0] mem [STACK_DEPTH];
  logic              error_seen, error_seen_next;
  token_t            tok, tok_next;
  logic              tok_err, tok_err_next;
  logic              tok_has, tok_has_next;
  result_t           pend, pend_next;
  logic              pend_v, pend_v_next;

  logic              has_top;
  logic              stk_full;
  logic              room;
  logic              pred_err;
  logic              do_push;
  logic              do_pop;
  logic [KIND_W-1:0] push_code;
  logic              emit;
  logic [OUT_W-1:0]  emit_kind;
  logic              end_step;
  logic              finish;
  logic [CNT_W-1:0]  wa_full;
  logic [CNT_W-1:0]  ra_full;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [IDX_W-1:0]  mem_ra;
  logic              flush_done;
  logic              idle_clear;

  assign has_top  = (stack_cnt != '0);
  assign stk_full = (stack_cnt == CNT_W'(STACK_DEPTH));
  assign room     = !pend_v || !res_full;

  always_comb begin
    pred_err = 1'b0;
    case (tok_head.cls)
      CLS_CLOSE: pred_err = (open_cnt == '0);
      CLS_OPEN:  pred_err = stk_full;
      CLS_OP:    pred_err = stk_full && !(prec_of(top) >= prec_of(tok_head.kind));
      default:   pred_err = 1'b0;
    endcase
  end

  always_comb begin
    state_next      = state;
    tok_next        = tok;
    tok_err_next    = tok_err;
    tok_has_next    = tok_has;
    error_seen_next = error_seen;
    tok_take        = 1'b0;
    do_push         = 1'b0;
    do_pop          = 1'b0;
    push_code       = tok.kind;
    emit            = 1'b0;
    emit_kind       = top[OUT_W-1:0];
    end_step        = 1'b0;
    finish          = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (tok_valid) begin
          tok_take        = 1'b1;
          tok_next        = tok_head;
          tok_err_next    = error_seen || pred_err;
          error_seen_next = error_seen || pred_err;
          tok_has_next    = 1'b0;
          case (tok_head.cls)
            CLS_OP:    state_next = S_OP;
            CLS_OPEN:  state_next = S_OPEN;
            CLS_CLOSE: state_next = S_CLOSE;
            default:   state_next = S_NUM;
          endcase
        end
      end
      S_NUM: begin
        if (tok.cls != CLS_NUM) begin
          end_step = 1'b1;
        end else if (room) begin
          emit      = 1'b1;
          emit_kind = OUT_NUMBER;
          end_step  = 1'b1;
        end
      end
      S_OP: begin
        if (has_top && (prec_of(top) >= prec_of(tok.kind))) begin
          if (room) begin
            do_pop = 1'b1;
            emit   = 1'b1;
          end
        end else begin
          do_push  = !stk_full;
          end_step = 1'b1;
        end
      end
      S_OPEN: begin
        do_push  = !stk_full;
        end_step = 1'b1;
      end
      S_CLOSE: begin
        if (has_top && !is_opener(top)) begin
          if (room) begin
            do_pop = 1'b1;
            emit   = 1'b1;
          end
        end else if (!has_top) begin
          end_step = 1'b1;
        end else if (top == KIND_SIN_OPEN || top == KIND_COS_OPEN) begin
          if (room) begin
            do_pop    = 1'b1;
            emit      = 1'b1;
            emit_kind = (top == KIND_SIN_OPEN) ? OUT_SIN : OUT_COS;
            end_step  = 1'b1;
          end
        end else begin
          do_pop   = 1'b1;
          end_step = 1'b1;
        end
      end
      S_FLUSH: begin
        if (has_top) begin
          if (is_opener(top)) begin
            do_pop = 1'b1;
          end else if (room) begin
            do_pop = 1'b1;
            emit   = 1'b1;
          end
        end else begin
          finish = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (emit) begin
      tok_has_next = 1'b1;
    end
    if (end_step) begin
      if (tok.expr_end) begin
        state_next = S_FLUSH;
      end else begin
        finish = 1'b1;
      end
    end
    if (finish) begin
      state_next = S_IDLE;
      if (tok.expr_end) begin
        error_seen_next = 1'b0;
      end
    end
  end

  // result staging: the newest result waits until its run flags are known
  always_comb begin
    pend_next   = pend;
    pend_v_next = pend_v;
    res_wr      = 1'b0;
    res_data    = pend;
    if (emit) begin
      res_wr       = pend_v;
      pend_v_next  = 1'b1;
      pend_next    = '{kind: emit_kind,
                       number: (emit_kind == OUT_NUMBER) ? tok.number : '0,
                       run_last: 1'b0, expr_done: 1'b0, err: tok_err};
    end else if (pend_v && pend.run_last && !res_full) begin
      res_wr      = 1'b1;
      pend_v_next = 1'b0;
    end
    if (finish && (emit || tok_has)) begin
      pend_next.run_last  = 1'b1;
      pend_next.expr_done = tok.expr_end;
    end
  end

  always_comb begin
    top_next       = top;
    stack_cnt_next = stack_cnt;
    open_cnt_next  = open_cnt;
    if (do_pop) begin
      top_next       = below;
      stack_cnt_next = stack_cnt - CNT_W'(1);
      if (is_opener(top)) begin
        open_cnt_next = open_cnt - CNT_W'(1);
      end
    end
    if (do_push) begin
      top_next       = push_code;
      stack_cnt_next = stack_cnt + CNT_W'(1);
      if (is_opener(push_code)) begin
        open_cnt_next = open_cnt + CNT_W'(1);
      end
    end
  end

  assign wa_full = stack_cnt - CNT_W'(1);
  assign ra_full = stack_cnt_next - CNT_W'(2);
  assign mem_we  = do_push && has_top;
  assign mem_wa  = wa_full[IDX_W-1:0];
  assign mem_ra  = ra_full[IDX_W-1:0];

  // entries below the cached top; read port tracks the next-to-top entry
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= top;
    end
    if (mem_we && (mem_wa == mem_ra)) begin
      below <= top;
    end else begin
      below <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      stack_cnt  <= '0;
      open_cnt   <= '0;
      error_seen <= 1'b0;
      tok_has    <= 1'b0;
      pend_v     <= 1'b0;
    end else begin
      state      <= state_next;
      stack_cnt  <= stack_cnt_next;
      open_cnt   <= open_cnt_next;
      error_seen <= error_seen_next;
      tok_has    <= tok_has_next;
      pend_v     <= pend_v_next;
    end
    top     <= top_next;
    tok     <= tok_next;
    tok_err <= tok_err_next;
    pend    <= pend_next;
  end

  assign flush_done = (state == S_FLUSH) && !has_top;
  assign idle_clear = (state == S_IDLE) && !error_seen && !has_top;

  `ITP_ASSERT_IMP(a_open_within_stack, 1'b1, open_cnt <= stack_cnt, "openers exceed depth")
  `ITP_ASSERT_IMP(a_write_has_room, res_wr, !res_full, "result written into a full queue")
  `ITP_ASSERT_NXT(a_flush_clears, flush_done, idle_clear, "flush left state behind")
  `ITP_ASSERT_IMP(a_idle_pend_final, state == S_IDLE && pend_v, pend.run_last, "open result idle")

endmodule

`default_nettype wire

FILE: design/itp_out_q.sv
// ----------------------------------------------------------------------------
// itp_out_q
// Result queue between the stack engine and the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itp_out_q
  import itp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             res_wr,
  input  result_t          res_data,
  output logic             res_full,
  output logic             empty,
  input  logic             pop,
  output logic [OUT_W-1:0] out_kind,
  output logic [NUM_W-1:0] out_number,
  output logic             run_last,
  output logic             expression_done,
  output logic             stack_error
);

  result_t             q [RQ_DEPTH];
  result_t             head;
  logic [RQ_PTR_W-1:0] wr_ptr;
  logic [RQ_PTR_W-1:0] rd_ptr;
  logic [RQ_CNT_W-1:0] cnt;
  logic                wr_en;
  logic                rd_en;

  assign res_full        = (cnt == RQ_CNT_W'(RQ_DEPTH));
  assign empty           = (cnt == '0);
  assign wr_en           = res_wr && !res_full;
  assign rd_en           = pop && !empty;
  assign head            = q[rd_ptr];
  assign out_kind        = head.kind;
  assign out_number      = head.number;
  assign run_last        = head.run_last;
  assign expression_done = head.expr_done;
  assign stack_error     = head.err;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : wr_ptr + RQ_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : rd_ptr + RQ_PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        cnt <= cnt + RQ_CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        cnt <= cnt - RQ_CNT_W'(1);
      end
    end
    if (wr_en) begin
      q[wr_ptr] <= res_data;
    end
  end

endmodule

`default_nettype wire

FILE: design/infix_to_postfix_converter_top.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// Usage: write infix tokens into the input queue (push while full is low),
// one token per item; read postfix tokens from the result queue (pop while
// empty is low). Each result carries run_last on the last item caused by a
// token, expression_done on the last item of an expression, and the sticky
// stack_error flag, which clears after an end-marked token.
// Processing: the stack engine takes a token only while idle, then pops
// entries one at a time (precedence pops, operators popped by a close and
// every entry of the end-of-expression flush); the opener a close drops is
// popped in the token's last step, and one more step closes a flush. The
// stack does one read/write per cycle. Operators are pushed once and
// popped once.
// Reset: synchronous; empties both queues, the operator stack and the
// error flag. No clearing pass is needed.
// Receiver stall: results collect in a 4-item queue plus one staging
// register; the engine then holds, and the 2-item input queue raises full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter_top
  import itp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [KIND_W-1:0] token_kind,
  input  logic [NUM_W-1:0]  number_bits,
  input  logic              expression_end,
  output logic              empty,
  input  logic              pop,
  output logic [OUT_W-1:0]  out_kind,
  output logic [NUM_W-1:0]  out_number,
  output logic              run_last,
  output logic              expression_done,
  output logic              stack_error
);

  logic    tok_valid;
  token_t  tok_head;
  logic    tok_take;
  logic    res_wr;
  result_t res_data;
  logic    res_full;

  itp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .token_kind     (token_kind),
    .number_bits    (number_bits),
    .expression_end (expression_end),
    .tok_valid      (tok_valid),
    .tok_head       (tok_head),
    .tok_take       (tok_take)
  );

  itp_stack u_stack (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok_head  (tok_head),
    .tok_take  (tok_take),
    .res_wr    (res_wr),
    .res_data  (res_data),
    .res_full  (res_full)
  );

  itp_out_q u_out_q (
    .clk             (clk),
    .rst             (rst),
    .res_wr          (res_wr),
    .res_data        (res_data),
    .res_full        (res_full),
    .empty           (empty),
    .pop             (pop),
    .out_kind        (out_kind),
    .out_number      (out_number),
    .run_last        (run_last),
    .expression_done (expression_done),
    .stack_error     (stack_error)
  );

endmodule

`default_nettype wire
